// ===== rtl/paired_byte_queue_table_top_assert.svh =====
// ============================================================================
// paired_byte_queue_table_top_assert.svh
// Assertion macros shared by the paired byte queue table.
// ============================================================================
`ifndef PAIRED_BYTE_QUEUE_TABLE_TOP_ASSERT_SVH
`define PAIRED_BYTE_QUEUE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PBQT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PBQT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pbqt_pkg.sv =====
// ============================================================================
// pbqt_pkg
// Operation codes, status codes and controller/datapath signal groups.
// ============================================================================
`default_nettype none

package pbqt_pkg;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_CLOSE = 2'd1,
    FN_READ  = 2'd2,
    FN_WRITE = 2'd3
  } pbqt_func_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd1;
  localparam logic [2:0] ST_NO_SLOT   = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic eval;
    logic pop_load;
    logic scan_step;
  } pbqt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_alloc;
    logic pop_go;
    logic scan_hit;
    logic scan_end;
  } pbqt_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pbqt_ctrl.sv =====
// ============================================================================
// pbqt_ctrl
// Sequencer: request capture, pointer fetch, evaluate, pop data, slot scan.
// ============================================================================
`default_nettype none

module pbqt_ctrl
  import pbqt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  pbqt_stat_t stat,
  output pbqt_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PTR,
    S_EVAL,
    S_POP,
    S_SCAN
  } state_t;

  state_t state;

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state == S_IDLE) && start;
    cmd.eval      = (state == S_EVAL);
    cmd.pop_load  = (state == S_POP);
    cmd.scan_step = (state == S_SCAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            busy  <= 1'b1;
            state <= stat.req_alloc ? S_SCAN : S_PTR;
          end
        end
        S_PTR: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (stat.pop_go) begin
            state <= S_POP;
          end else begin
            state <= S_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        S_POP: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        S_SCAN: begin
          // stop at the first free slot or past the last one
          if (stat.scan_hit || stat.scan_end) begin
            state <= S_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pbqt_datapath.sv =====
// ============================================================================
// pbqt_datapath
// Slot flags, per-slot pointer memory, byte stores and result registers.
// ============================================================================
`default_nettype none

module pbqt_datapath
  import pbqt_pkg::*;
#(
  parameter int SLOTS       = 16,
  parameter int QUEUE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  pbqt_cmd_t  cmd,
  output pbqt_stat_t stat,
  input  logic [1:0] func,
  input  logic [3:0] slot,
  input  logic       from_master,
  input  logic [7:0] data_in,
  input  logic       last_in,
  output logic [2:0] status,
  output logic [7:0] data_out,
  output logic [3:0] slot_out,
  output logic       last_out
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [PTR_W-1:0]  dh;
    logic [PTR_W-1:0]  dt;
    logic [FILL_W-1:0] df;
    logic [PTR_W-1:0]  uh;
    logic [PTR_W-1:0]  ut;
    logic [FILL_W-1:0] uf;
  } ptr_rec_t;

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    next_pos = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // captured request
  pbqt_func_t        func_q;
  logic [3:0]        slot_q;
  logic              use_down_q;
  logic [7:0]        data_q;
  logic [SLOT_W-1:0] scan_idx;

  logic [SLOTS-1:0]  in_use;
  ptr_rec_t          ptr_mem [SLOTS];
  ptr_rec_t          rec_q;
  logic [7:0]        down_mem [SLOTS][QUEUE_DEPTH];
  logic [7:0]        up_mem   [SLOTS][QUEUE_DEPTH];
  logic [7:0]        down_rd_q;
  logic [7:0]        up_rd_q;

  logic [SLOT_W-1:0] slot_idx;
  logic              slot_ok;
  logic              scan_hit;
  logic              scan_end;

  logic [2:0]        eval_status;
  ptr_rec_t          rec_next;
  logic              rec_wr;
  logic              push_dn;
  logic              push_up;
  logic              release_slot;
  logic              pop_go;

  logic              ptr_we;
  logic [SLOT_W-1:0] ptr_waddr;
  ptr_rec_t          ptr_wdata;

  assign slot_idx = SLOT_W'(slot_q);
  assign slot_ok  = (32'(slot_q) < 32'(SLOTS)) && in_use[slot_idx];
  assign scan_hit = !in_use[scan_idx];
  assign scan_end = (scan_idx == SLOT_W'(SLOTS - 1));

  assign stat.req_alloc = (pbqt_func_t'(func) == FN_ALLOC);
  assign stat.pop_go    = pop_go;
  assign stat.scan_hit  = scan_hit;
  assign stat.scan_end  = scan_end;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q     <= pbqt_func_t'(func);
      slot_q     <= slot;
      // master writes go down, master reads come up
      use_down_q <= (pbqt_func_t'(func) == FN_READ) ? !from_master : from_master;
      data_q     <= data_in;
      last_out   <= last_in;
      scan_idx   <= '0;
    end else if (cmd.scan_step && !scan_hit && !scan_end) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  always_comb begin
    eval_status  = ST_OK;
    rec_next     = rec_q;
    rec_wr       = 1'b0;
    push_dn      = 1'b0;
    push_up      = 1'b0;
    release_slot = 1'b0;
    pop_go       = 1'b0;
    if (!slot_ok) begin
      eval_status = ST_NOT_ALLOC;
    end else begin
      unique case (func_q)
        FN_CLOSE: begin
          rec_next     = '0;
          rec_wr       = 1'b1;
          release_slot = 1'b1;
        end
        FN_READ: begin
          if (use_down_q) begin
            if (rec_q.df == '0) begin
              eval_status = ST_EMPTY;
            end else begin
              pop_go      = 1'b1;
              rec_wr      = 1'b1;
              rec_next.dh = next_pos(rec_q.dh);
              rec_next.df = rec_q.df - 1'b1;
            end
          end else begin
            if (rec_q.uf == '0) begin
              eval_status = ST_EMPTY;
            end else begin
              pop_go      = 1'b1;
              rec_wr      = 1'b1;
              rec_next.uh = next_pos(rec_q.uh);
              rec_next.uf = rec_q.uf - 1'b1;
            end
          end
        end
        FN_WRITE: begin
          if (use_down_q) begin
            if (rec_q.df == FILL_W'(QUEUE_DEPTH)) begin
              eval_status = ST_FULL;
            end else begin
              push_dn     = 1'b1;
              rec_wr      = 1'b1;
              rec_next.dt = next_pos(rec_q.dt);
              rec_next.df = rec_q.df + 1'b1;
            end
          end else begin
            if (rec_q.uf == FILL_W'(QUEUE_DEPTH)) begin
              eval_status = ST_FULL;
            end else begin
              push_up     = 1'b1;
              rec_wr      = 1'b1;
              rec_next.ut = next_pos(rec_q.ut);
              rec_next.uf = rec_q.uf + 1'b1;
            end
          end
        end
        FN_ALLOC: begin
          // allocate runs through the scan, never here
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else begin
      if (cmd.scan_step && scan_hit) begin
        in_use[scan_idx] <= 1'b1;
      end
      if (cmd.eval && release_slot) begin
        in_use[slot_idx] <= 1'b0;
      end
    end
  end

  // a granted slot gets its pointers cleared, so stale entries are never used
  assign ptr_we    = (cmd.eval && rec_wr) || (cmd.scan_step && scan_hit);
  assign ptr_waddr = cmd.scan_step ? scan_idx : slot_idx;
  assign ptr_wdata = cmd.scan_step ? ptr_rec_t'('0) : rec_next;

  always_ff @(posedge clk) begin
    if (ptr_we) begin
      ptr_mem[ptr_waddr] <= ptr_wdata;
    end
    rec_q <= ptr_mem[slot_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && push_dn) begin
      down_mem[slot_idx][rec_q.dt] <= data_q;
    end
    down_rd_q <= down_mem[slot_idx][rec_q.dh];
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && push_up) begin
      up_mem[slot_idx][rec_q.ut] <= data_q;
    end
    up_rd_q <= up_mem[slot_idx][rec_q.uh];
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      status   <= eval_status;
      data_out <= '0;
      slot_out <= '0;
    end else if (cmd.pop_load) begin
      data_out <= use_down_q ? down_rd_q : up_rd_q;
    end else if (cmd.scan_step && (scan_hit || scan_end)) begin
      status   <= scan_hit ? ST_OK : ST_NO_SLOT;
      data_out <= '0;
      slot_out <= scan_hit ? 4'(scan_idx) : 4'd0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/paired_byte_queue_table_top.sv =====
// ============================================================================
// paired_byte_queue_table_top
// Slot table with one down and one up byte queue per slot.
// ============================================================================
// Usage:
//   Present func, slot, from_master, data_in and last_in with start high; the
//   request is taken at the clock edge where start is high and busy is low.
//   busy stays high until the result is out. The result (status, data_out,
//   slot_out, last_out) is valid for exactly one cycle with done high; the
//   receiver must take it then. A new request may be started in that cycle.
//   The sequencer runs a registered pointer-memory read, then the pointer
//   update, and for pops a registered byte-store read; allocate scans the
//   slot flags one a cycle, from slot 0 up to the lowest free one or the last.
//   One request is handled at a time.
//   Reset clears all slot flags: every slot is free and no queue holds data.
//   Pointers are rewritten when a slot is granted, so no clearing pass runs.
// ============================================================================
`default_nettype none

module paired_byte_queue_table_top
  import pbqt_pkg::*;
#(
  parameter int SLOTS       = 16,
  parameter int QUEUE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func,
  input  logic [3:0] slot,
  input  logic       from_master,
  input  logic [7:0] data_in,
  input  logic       last_in,
  output logic       done,
  output logic [2:0] status,
  output logic [7:0] data_out,
  output logic [3:0] slot_out,
  output logic       last_out
);

  `include "paired_byte_queue_table_top_assert.svh"

  pbqt_cmd_t  cmd;
  pbqt_stat_t stat;

  pbqt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pbqt_datapath #(
    .SLOTS       (SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (func),
    .slot        (slot),
    .from_master (from_master),
    .data_in     (data_in),
    .last_in     (last_in),
    .status      (status),
    .data_out    (data_out),
    .slot_out    (slot_out),
    .last_out    (last_out)
  );

  `PBQT_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
  `PBQT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done,
                    "accepted request did not hold busy")
  `PBQT_ASSERT_NOW(a_fail_zero, done && (status != ST_OK),
                   (data_out == 8'd0) && (slot_out == 4'd0),
                   "failed request returned nonzero data or slot")
  `PBQT_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe longer than one cycle")

endmodule

`default_nettype wire
